// File: design/tsa_pkg.sv
// Package for the task slot allocator: sizes, codes and the item types
// shared by the controller, the datapath and the top level.
// No dependencies.
package tsa_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int NUM_REGULAR = 48;
  localparam int INDEX_BITS  = 6;
  localparam int TID_BITS    = 16;
  localparam int GEN_BITS    = TID_BITS - INDEX_BITS;

  localparam int ADDR_W    = 32;
  localparam int KSIZE_W   = 24;
  localparam int SSIZE_W   = 20;
  localparam int COUNT_W   = 8;
  localparam int PRIO_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] ALIGN_MASK = 32'h3;

  localparam logic [KSIZE_W-1:0] KERNEL_SIZE_RST  = 24'd65536;
  localparam logic [SSIZE_W-1:0] REGULAR_SIZE_RST = 20'd65536;
  localparam logic [SSIZE_W-1:0] MICRO_SIZE_RST   = 20'd4096;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_EXIT   = 2'd1,
    REQ_READY  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_BAD_ID  = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    SLOT_INVALID = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_EXITED  = 2'd2
  } slot_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STACK_TOP    = 2'd0,
    CFG_KERNEL_SIZE  = 2'd1,
    CFG_REGULAR_SIZE = 2'd2,
    CFG_MICRO_SIZE   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic                task_type;
    logic [TID_BITS-1:0] tid;
    logic [TID_BITS-1:0] parent_id;
    logic [PRIO_W-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TID_BITS-1:0] task_id;
    logic [TID_BITS-1:0] parent_out;
    logic [1:0]          state_out;
    logic                type_out;
    logic [PRIO_W-1:0]   priority_out;
    logic [ADDR_W-1:0]   stack_base;
    logic [COUNT_W-1:0]  regular_in_use;
    logic [COUNT_W-1:0]  micro_in_use;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic look;
    logic exec;
    logic fin;
  } tsa_cmd_t;

endpackage

// File: design/tsa_ctrl.sv
// Controller for the task slot allocator: sequences one item through the
// look-up, execute and finish steps of the datapath.
// Depends on tsa_pkg.
module tsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output tsa_pkg::tsa_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_LOOK;
      end
      S_LOOK:  state_next = S_EXEC;
      S_EXEC:  state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
    end
  end

  assign busy     = (state != S_IDLE);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.look = (state == S_LOOK);
  assign cmd.exec = (state == S_EXEC);
  assign cmd.fin  = (state == S_FIN);

endmodule

// File: design/tsa_dp.sv
// Datapath for the task slot allocator: configuration registers, slot table
// memory, ready flags, free-slot search, in-use counters and stack base math.
// Depends on tsa_pkg; driven by commands from tsa_ctrl.
module tsa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  tsa_pkg::tsa_cmd_t               cmd,
  input  tsa_pkg::req_t                   req,
  input  logic                            cfg_we,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsa_pkg::ADDR_W-1:0]      cfg_data,
  output tsa_pkg::rsp_t                   rsp
);

  typedef struct packed {
    logic [tsa_pkg::GEN_BITS-1:0] gen;
    logic [tsa_pkg::TID_BITS-1:0] parent;
    logic [tsa_pkg::PRIO_W-1:0]   prio;
    logic [1:0]                   state;
  } entry_t;

  localparam int PROD_W = tsa_pkg::INDEX_BITS + tsa_pkg::SSIZE_W;

  // Configuration.
  logic [tsa_pkg::ADDR_W-1:0]  stack_top;
  logic [tsa_pkg::KSIZE_W-1:0] kernel_size;
  logic [tsa_pkg::SSIZE_W-1:0] regular_size;
  logic [tsa_pkg::SSIZE_W-1:0] micro_size;

  // Slot table.
  entry_t                         mem [tsa_pkg::NUM_SLOTS];
  logic [tsa_pkg::NUM_SLOTS-1:0]  written;
  logic [tsa_pkg::NUM_SLOTS-1:0]  ready_vec;
  logic [tsa_pkg::COUNT_W-1:0]    regular_count;
  logic [tsa_pkg::COUNT_W-1:0]    micro_count;

  // Item state.
  tsa_pkg::req_t                  req_r;
  logic [tsa_pkg::INDEX_BITS-1:0] idx_r;
  logic                           hit_r;
  logic                           was_ready_r;
  entry_t                         entry_r;
  logic                           entry_vld_r;
  logic                           found_r;
  logic [PROD_W-1:0]              prod_r;
  logic [tsa_pkg::ADDR_W-1:0]     base_pre_r;

  // Result registers.
  logic [1:0]                     status_r;
  logic [tsa_pkg::TID_BITS-1:0]   task_id_r;
  logic [tsa_pkg::TID_BITS-1:0]   parent_r;
  logic [1:0]                     state_r;
  logic                           type_r;
  logic [tsa_pkg::PRIO_W-1:0]     prio_r;
  logic [tsa_pkg::ADDR_W-1:0]     stack_base_r;

  // Look-up step signals.
  logic                           enc_found;
  logic [tsa_pkg::INDEX_BITS-1:0] enc_idx;
  logic [tsa_pkg::INDEX_BITS-1:0] sel_idx;
  logic                           sel_hit;
  logic                           is_create;

  // Execute step signals.
  entry_t                         cur;
  entry_t                         upd;
  logic                           is_micro;
  logic                           found;
  logic                           wr_en;
  logic                           new_ready;
  logic [tsa_pkg::INDEX_BITS-1:0] off_idx;
  logic [tsa_pkg::SSIZE_W-1:0]    size_sel;
  logic [PROD_W-1:0]              prod_next;
  logic [tsa_pkg::ADDR_W-1:0]     micro_skip;
  logic [tsa_pkg::ADDR_W-1:0]     base_pre_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top    <= '0;
      kernel_size  <= tsa_pkg::KERNEL_SIZE_RST;
      regular_size <= tsa_pkg::REGULAR_SIZE_RST;
      micro_size   <= tsa_pkg::MICRO_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsa_pkg::CFG_STACK_TOP:    stack_top    <= cfg_data;
        tsa_pkg::CFG_KERNEL_SIZE:  kernel_size  <= cfg_data[tsa_pkg::KSIZE_W-1:0];
        tsa_pkg::CFG_REGULAR_SIZE: regular_size <= cfg_data[tsa_pkg::SSIZE_W-1:0];
        tsa_pkg::CFG_MICRO_SIZE:   micro_size   <= cfg_data[tsa_pkg::SSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_create = (req_r.req_type == tsa_pkg::REQ_CREATE);

  // Lowest slot that is not ready in the requested range; the loop runs
  // downward so the lowest match is the one that stays.
  always_comb begin
    enc_found = 1'b0;
    enc_idx   = '0;
    for (int i = tsa_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if ((req_r.task_type ? (i >= tsa_pkg::NUM_REGULAR) : (i < tsa_pkg::NUM_REGULAR))
          && !ready_vec[i]) begin
        enc_found = 1'b1;
        enc_idx   = tsa_pkg::INDEX_BITS'(i);
      end
    end
  end

  always_comb begin
    if (is_create) begin
      sel_idx = enc_idx;
      sel_hit = enc_found;
    end else begin
      sel_idx = req_r.tid[tsa_pkg::INDEX_BITS-1:0];
      sel_hit = ({1'b0, sel_idx} < (tsa_pkg::INDEX_BITS+1)'(tsa_pkg::NUM_SLOTS));
    end
  end

  always_comb begin
    cur      = entry_vld_r ? entry_r : '0;
    is_micro = ({1'b0, idx_r} >= (tsa_pkg::INDEX_BITS+1)'(tsa_pkg::NUM_REGULAR));
    if (is_create) begin
      found = hit_r;
    end else begin
      found = hit_r && (cur.gen == req_r.tid[tsa_pkg::TID_BITS-1:tsa_pkg::INDEX_BITS]);
    end
    upd = cur;
    case (req_r.req_type)
      tsa_pkg::REQ_CREATE: begin
        upd.gen    = cur.gen + 1'b1;
        upd.parent = req_r.parent_id;
        upd.prio   = req_r.priority_req;
        upd.state  = tsa_pkg::SLOT_READY;
      end
      tsa_pkg::REQ_EXIT:  upd.state = tsa_pkg::SLOT_EXITED;
      tsa_pkg::REQ_READY: upd.state = tsa_pkg::SLOT_READY;
      default: ;
    endcase
    wr_en     = cmd.exec && found && (req_r.req_type != tsa_pkg::REQ_QUERY);
    new_ready = (upd.state == tsa_pkg::SLOT_READY);

    off_idx  = is_micro ? idx_r - tsa_pkg::INDEX_BITS'(tsa_pkg::NUM_REGULAR) : idx_r;
    size_sel = is_micro ? micro_size : regular_size;
    prod_next = PROD_W'(off_idx) * PROD_W'(size_sel);
    micro_skip = is_micro
        ? tsa_pkg::ADDR_W'(regular_size) * tsa_pkg::ADDR_W'(tsa_pkg::NUM_REGULAR)
        : '0;
    base_pre_next = stack_top - tsa_pkg::ADDR_W'(kernel_size) - micro_skip;
  end

  // Table memory: one read during look-up, one write during execute.
  always_ff @(posedge clk) begin
    if (cmd.look) entry_r <= mem[sel_idx];
    if (wr_en) mem[idx_r] <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written       <= '0;
      ready_vec     <= '0;
      regular_count <= '0;
      micro_count   <= '0;
    end else if (wr_en) begin
      written[idx_r]   <= 1'b1;
      ready_vec[idx_r] <= new_ready;
      if (new_ready && !was_ready_r) begin
        if (is_micro) micro_count <= micro_count + 1'b1;
        else regular_count <= regular_count + 1'b1;
      end else if (!new_ready && was_ready_r) begin
        if (is_micro) micro_count <= micro_count - 1'b1;
        else regular_count <= regular_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req;
    if (cmd.look) begin
      idx_r       <= sel_idx;
      hit_r       <= sel_hit;
      entry_vld_r <= written[sel_idx];
      was_ready_r <= ready_vec[sel_idx];
    end
    if (cmd.exec) begin
      found_r    <= found;
      prod_r     <= prod_next;
      base_pre_r <= base_pre_next;
      if (found) begin
        status_r  <= tsa_pkg::STAT_OK;
        task_id_r <= {upd.gen, idx_r};
        parent_r  <= upd.parent;
        state_r   <= upd.state;
        type_r    <= is_micro;
        prio_r    <= upd.prio;
      end else begin
        status_r  <= is_create ? tsa_pkg::STAT_NO_SLOT : tsa_pkg::STAT_BAD_ID;
        task_id_r <= '0;
        parent_r  <= '0;
        state_r   <= tsa_pkg::SLOT_INVALID;
        type_r    <= 1'b0;
        prio_r    <= '0;
      end
    end
    if (cmd.fin) begin
      stack_base_r <= found_r
          ? ((base_pre_r - tsa_pkg::ADDR_W'(prod_r)) & ~tsa_pkg::ALIGN_MASK)
          : '0;
    end
  end

  assign rsp.status         = status_r;
  assign rsp.task_id        = task_id_r;
  assign rsp.parent_out     = parent_r;
  assign rsp.state_out      = state_r;
  assign rsp.type_out       = type_r;
  assign rsp.priority_out   = prio_r;
  assign rsp.stack_base     = stack_base_r;
  assign rsp.regular_in_use = regular_count;
  assign rsp.micro_in_use   = micro_count;

endmodule

// File: design/task_slot_allocator_unit.sv
// Task slot allocator: a table of task slots addressed by generation-counted
// task IDs, with create, exit, make-ready and query requests.
//
// Request channel: an item is taken at a clock edge where start is high and
// busy is low. Done rises after the finish step and marks the result on rsp
// for exactly one cycle; the receiver cannot hold it off. Busy falls while
// the result is shown, so a new item can be taken at the edge that ends that
// cycle; busy stays high until then, so one item is handled at a time.
// Each item passes the look-up, execute and finish steps in order: look-up
// finds the slot (free-slot search on create) and issues the table read,
// execute checks the generation, writes the table and multiplies the slot's
// stack offset, finish does the stack base subtraction, and then the result
// is shown.
// Configuration channel: cfg_valid with cfg_index and cfg_data writes one
// register; cfg_ready is always high. Write it only while no item is open.
// Reset (rst, synchronous) marks every slot invalid with generation zero,
// clears the in-use counts and loads the default stack sizes; the block is
// ready for an item in the first cycle after reset.
// Depends on tsa_pkg, tsa_ctrl and tsa_dp.
module task_slot_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tsa_pkg::req_t                 req,
  output logic                          done,
  output tsa_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsa_pkg::ADDR_W-1:0]    cfg_data
);

  tsa_pkg::tsa_cmd_t cmd;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for task_slot_allocator_unit: directed and random create, exit,
// make-ready and query items are checked against a behavioral slot table.
// Depends on tsa_pkg and the allocator RTL.
module tb_top;
  import tsa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_GAP     = 40;
  localparam int DRAIN_TAIL  = 6;

  // Behavioral copy of the slot table. Every accepted item updates it and queues the
  // result the block must return for that item.
  class slot_table_model;
    logic [GEN_BITS-1:0] gen [NUM_SLOTS];
    slot_state_t         st [NUM_SLOTS];
    logic [TID_BITS-1:0] parent [NUM_SLOTS];
    logic [PRIO_W-1:0]   prio [NUM_SLOTS];
    logic [ADDR_W-1:0]   stack_top;
    logic [KSIZE_W-1:0]  kernel_size;
    logic [SSIZE_W-1:0]  regular_size;
    logic [SSIZE_W-1:0]  micro_size;
    rsp_t                replies_due [$];
    int unsigned         errors, items_seen, granted, refused, bad_ids;
    int unsigned         peak_regular, peak_micro;

    function void clear();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        gen[i]    = '0;
        st[i]     = SLOT_INVALID;
        parent[i] = '0;
        prio[i]   = '0;
      end
      stack_top    = '0;
      kernel_size  = KERNEL_SIZE_RST;
      regular_size = REGULAR_SIZE_RST;
      micro_size   = MICRO_SIZE_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        CFG_STACK_TOP:    stack_top    = data;
        CFG_KERNEL_SIZE:  kernel_size  = data[KSIZE_W-1:0];
        CFG_REGULAR_SIZE: regular_size = data[SSIZE_W-1:0];
        CFG_MICRO_SIZE:   micro_size   = data[SSIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [TID_BITS-1:0] id_of(int unsigned idx);
      logic [INDEX_BITS-1:0] ix;
      ix = idx[INDEX_BITS-1:0];
      return {gen[idx], ix};
    endfunction

    // Stacks grow down from stack_top: kernel area first, then the regular slots, then
    // the micro slots. The subtraction wraps at 32 bits before word alignment.
    function logic [ADDR_W-1:0] base_of(int unsigned idx);
      logic [63:0]       off;
      logic [ADDR_W-1:0] b;
      if (idx < NUM_REGULAR) begin
        off = 64'(kernel_size) + 64'(idx) * 64'(regular_size);
      end else begin
        off = 64'(kernel_size) + 64'(NUM_REGULAR) * 64'(regular_size)
            + 64'(idx - NUM_REGULAR) * 64'(micro_size);
      end
      b = stack_top - off[ADDR_W-1:0];
      return b & ~ALIGN_MASK;
    endfunction

    function rsp_t predict(req_t r);
      rsp_t        o;
      int unsigned idx, lo, hi, n_reg, n_micro;
      logic        hit;
      o   = '0;
      idx = 0;
      hit = 1'b0;
      if (r.req_type == REQ_CREATE) begin
        lo = r.task_type ? NUM_REGULAR : 0;
        hi = r.task_type ? NUM_SLOTS : NUM_REGULAR;
        for (int unsigned i = lo; i < hi && !hit; i++) begin
          if (st[i] != SLOT_READY) begin
            idx = i;
            hit = 1'b1;
          end
        end
        if (hit) begin
          gen[idx]    = gen[idx] + 1'b1;
          parent[idx] = r.parent_id;
          prio[idx]   = r.priority_req;
          st[idx]     = SLOT_READY;
          granted++;
        end else begin
          o.status = STAT_NO_SLOT;
          refused++;
        end
      end else begin
        idx = r.tid[INDEX_BITS-1:0];
        if (idx < NUM_SLOTS && id_of(idx) == r.tid) begin
          hit = 1'b1;
          if (r.req_type == REQ_EXIT) st[idx] = SLOT_EXITED;
          else if (r.req_type == REQ_READY) st[idx] = SLOT_READY;
        end else begin
          o.status = STAT_BAD_ID;
          bad_ids++;
        end
      end
      if (hit) begin
        o.task_id      = id_of(idx);
        o.parent_out   = parent[idx];
        o.state_out    = st[idx];
        o.type_out     = (idx >= NUM_REGULAR);
        o.priority_out = prio[idx];
        o.stack_base   = base_of(idx);
      end
      n_reg   = 0;
      n_micro = 0;
      for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
        if (st[i] == SLOT_READY) begin
          if (i < NUM_REGULAR) n_reg++;
          else n_micro++;
        end
      end
      o.regular_in_use = n_reg[COUNT_W-1:0];
      o.micro_in_use   = n_micro[COUNT_W-1:0];
      if (n_reg > peak_regular) peak_regular = n_reg;
      if (n_micro > peak_micro) peak_micro = n_micro;
      return o;
    endfunction

    function void note_request(req_t r);
      items_seen++;
      replies_due.push_back(predict(r));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = replies_due.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("task_id", 32'(want.task_id), 32'(got.task_id));
      compare_field("parent_out", 32'(want.parent_out), 32'(got.parent_out));
      compare_field("state_out", 32'(want.state_out), 32'(got.state_out));
      compare_field("type_out", 32'(want.type_out), 32'(got.type_out));
      compare_field("priority_out", 32'(want.priority_out), 32'(got.priority_out));
      compare_field("stack_base", want.stack_base, got.stack_base);
      compare_field("regular_in_use", 32'(want.regular_in_use), 32'(got.regular_in_use));
      compare_field("micro_in_use", 32'(want.micro_in_use), 32'(got.micro_in_use));
    endfunction

    function int unsigned outstanding();
      return replies_due.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  req_t                 req       = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;

  slot_table_model slots = new();
  int              idle_pct      = 0;
  int unsigned     cycle_count   = 0;
  int unsigned     setting_count = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task_slot_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The result check comes first so that an item taken in the same cycle as a
  // result is not matched against it.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) slots.check_result(rsp);
      if (cfg_valid && cfg_ready) slots.write_reg(cfg_index, cfg_data);
      if (start && !busy) slots.note_request(req);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("task_slot_allocator_unit verification failed");
    $finish;
  end

  task automatic send_item(input req_t r);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req   <= req_t'({$urandom, $urandom});
      @(posedge clk);
      gap++;
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue(input req_code_t op, input logic ttype, input logic [15:0] tid,
                       input logic [15:0] parent_id, input logic [4:0] prio);
    req_t r;
    r.req_type     = op;
    r.task_type    = ttype;
    r.tid          = tid;
    r.parent_id    = parent_id;
    r.priority_req = prio;
    send_item(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (slots.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_one(input cfg_index_t idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] top, input logic [31:0] kern,
                              input logic [31:0] regs, input logic [31:0] micro);
    write_one(CFG_STACK_TOP, top);
    write_one(CFG_KERNEL_SIZE, kern);
    write_one(CFG_REGULAR_SIZE, regs);
    write_one(CFG_MICRO_SIZE, micro);
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // Most non-create items carry the live ID of some slot so that they get past the
  // generation check; the rest carry a stale generation or random bits.
  function automatic req_t random_request(int create_pct);
    req_t                r;
    logic [TID_BITS-1:0] cur;
    int unsigned         roll;
    r.req_type     = REQ_CREATE;
    r.task_type    = 1'($urandom_range(1));
    r.tid          = 16'($urandom);
    r.parent_id    = 16'($urandom);
    r.priority_req = 5'($urandom);
    if ($urandom_range(99) >= create_pct) begin
      case ($urandom_range(2))
        0: r.req_type = REQ_EXIT;
        1: r.req_type = REQ_READY;
        default: r.req_type = REQ_QUERY;
      endcase
      cur  = slots.id_of($urandom_range(NUM_SLOTS - 1));
      roll = $urandom_range(99);
      if (roll < 70) r.tid = cur;
      else if (roll < 85) r.tid = cur ^ (TID_BITS'(1) << $urandom_range(TID_BITS - 1, INDEX_BITS));
    end
    return r;
  endfunction

  task automatic run_random(input int count, input int create_pct);
    for (int n = 0; n < count; n++) send_item(random_request(create_pct));
  endtask

  initial begin
    slots.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fresh table: never-used slots match generation zero, so they can be queried,
    // exited and made ready before any create.
    issue(REQ_QUERY,  1'b0, 16'h0000, 16'h0000, 5'd0);
    issue(REQ_EXIT,   1'b1, 16'h0001, 16'hFFFF, 5'd31);
    issue(REQ_READY,  1'b0, 16'h0002, 16'hFFFF, 5'd31);
    issue(REQ_CREATE, 1'b0, 16'hFFFF, 16'hFFFF, 5'd31);
    issue(REQ_CREATE, 1'b1, 16'h0000, 16'h0000, 5'd0);
    issue(REQ_QUERY,  1'b0, 16'h0000, 16'h0000, 5'd0);
    issue(REQ_EXIT,   1'b0, 16'h0040, 16'h0000, 5'd0);
    issue(REQ_EXIT,   1'b0, 16'h0040, 16'h0000, 5'd0);
    issue(REQ_READY,  1'b1, 16'h0040, 16'hAAAA, 5'd21);
    issue(REQ_EXIT,   1'b0, 16'h0040, 16'h0000, 5'd0);
    issue(REQ_CREATE, 1'b0, 16'h0000, 16'h1234, 5'd7);
    issue(REQ_CREATE, 1'b0, 16'h5555, 16'h5555, 5'd10);
    issue(REQ_CREATE, 1'b0, 16'h0000, 16'h8001, 5'd16);
    issue(REQ_QUERY,  1'b0, 16'hFFFF, 16'h0000, 5'd0);
    issue(REQ_QUERY,  1'b0, 16'h003F, 16'h0000, 5'd0);
    issue(REQ_READY,  1'b0, 16'h003F, 16'h0000, 5'd0);
    issue(REQ_QUERY,  1'b0, 16'h0070, 16'h0000, 5'd0);
    issue(REQ_EXIT,   1'b0, 16'h0070, 16'h0000, 5'd0);
    issue(REQ_CREATE, 1'b1, 16'h0000, 16'h7FFF, 5'd1);
    issue(REQ_QUERY,  1'b0, 16'h0080, 16'h0000, 5'd0);
    issue(REQ_EXIT,   1'b0, 16'hFFC0, 16'h0000, 5'd0);

    run_random(130, 55);
    drain();

    idle_pct = 84;
    program_regs(32'h0, 32'h0, 32'h0, 32'h0);
    run_random(65, 35);
    drain();
    run_random(65, 35);
    drain();

    idle_pct = 36;
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(130, 45);
    drain();

    idle_pct = 0;
    program_regs($urandom, $urandom, $urandom, $urandom);
    run_random(130, 70);
    drain();

    // A low stack top with odd sizes gives bases that need alignment.
    idle_pct = 84;
    program_regs(32'h0000_1000 + $urandom_range(255), 32'h0000_0005, 32'h0000_0001,
                 32'h0000_0003);
    run_random(130, 40);
    drain();

    $display("Ran %0d items over %0d register settings: %0d creates granted, %0d refused,",
             slots.items_seen, setting_count, slots.granted, slots.refused);
    $display("%0d stale or unknown IDs; peak in use %0d regular and %0d micro slots.",
             slots.bad_ids, slots.peak_regular, slots.peak_micro);
    if (slots.errors == 0) begin
      $display("task_slot_allocator_unit verification clean");
    end else begin
      $display("task_slot_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
